[hw/rtl/lsbp_pkg.sv]
// shared constants, types and record layouts of the lsb-first bit packer
package lsbp_pkg;

  // buffer geometry
  localparam int BufferBytes = 4096;
  localparam int AddrW       = $clog2(BufferBytes);
  localparam int CursorW     = 16;
  localparam int RoomMax     = (BufferBytes * 8 < 65535) ? BufferBytes * 8 : 65535;
  localparam logic [CursorW-1:0] CapacityReset = 16'd32768;

  // field widths fixed by the interface
  localparam int DataW  = 8;
  localparam int ChunkW = 4;
  localparam int OutAddrW = 12;
  localparam logic [ChunkW-1:0] ChunkMax = 4'd8;

  // front-to-back queue
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  // classified chunk handed from the front to the back
  typedef struct packed {
    logic                 status;
    logic [CursorW-1:0]   cursor;
    logic                 wr_lo;
    logic                 wr_hi;
    logic [AddrW-1:0]     addr;
    logic [2*DataW-1:0]   mask;
    logic [2*DataW-1:0]   bits;
  } lsbp_op_t;

  // one result record
  typedef struct packed {
    logic               status;
    logic               write_valid;
    logic [AddrW-1:0]   addr;
    logic [DataW-1:0]   value;
    logic [CursorW-1:0] cursor;
    logic               last;
  } lsbp_res_t;

endpackage

[hw/rtl/lsbp_ram.sv]
// generic single-write, single-read ram with registered read data
module lsbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/lsbp_front.sv]
// front end: call check, cursor tracking and chunk classification
module lsbp_front import lsbp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CursorW-1:0]  cfg_wdata_i,
  input  logic                accept_i,
  input  logic [DataW-1:0]    data_bits_i,
  input  logic [ChunkW-1:0]   chunk_bits_i,
  input  logic                first_of_call_i,
  input  logic [CursorW-1:0]  call_bits_i,
  output lsbp_op_t            op_o
);

  logic [CursorW-1:0]   capacity_q;
  logic [CursorW-1:0]   cursor_q, cursor_d;
  logic                 refused_q, refused_d;

  logic [ChunkW-1:0]    n;
  logic [CursorW:0]     sum_call, sum_chunk;
  logic                 refuse_call;
  logic [CursorW-1:0]   limit;
  logic                 drop;
  logic [DataW-1:0]     base_mask;
  logic [2*DataW-1:0]   mask;
  logic [CursorW-4:0]   idx;

  // chunk length saturates at one byte
  assign n = (chunk_bits_i > ChunkMax) ? ChunkMax : chunk_bits_i;

  // call room check and chunk room check side by side
  assign sum_call    = {1'b0, cursor_q} + {1'b0, call_bits_i};
  assign refuse_call = sum_call > {1'b0, capacity_q};
  assign limit       = (capacity_q < CursorW'(RoomMax)) ? capacity_q : CursorW'(RoomMax);
  assign sum_chunk   = {1'b0, cursor_q} + (CursorW + 1)'(n);

  assign refused_d = first_of_call_i ? refuse_call : refused_q;
  assign drop      = refused_d || (n == '0) || (sum_chunk > {1'b0, limit});

  // cursor after this chunk
  always_comb begin
    if (first_of_call_i && refuse_call) begin
      cursor_d = capacity_q;
    end else if (drop) begin
      cursor_d = cursor_q;
    end else begin
      cursor_d = sum_chunk[CursorW-1:0];
    end
  end

  // byte lane masks at the current bit offset
  assign base_mask = DataW'(((DataW + 1)'(1) << n) - (DataW + 1)'(1));
  assign mask      = {{DataW{1'b0}}, base_mask} << cursor_q[2:0];
  assign idx       = cursor_q[CursorW-1:3];

  always_comb begin
    op_o.status = refused_d;
    op_o.cursor = cursor_d;
    op_o.wr_lo  = !drop;
    op_o.wr_hi  = !drop && (mask[2*DataW-1:DataW] != '0) &&
                  ((17'(idx) + 17'd1) < 17'(BufferBytes));
    op_o.addr   = AddrW'(idx);
    op_o.mask   = mask;
    op_o.bits   = ({{DataW{1'b0}}, data_bits_i} << cursor_q[2:0]) & mask;
  end

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityReset;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // cursor and refusal state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q  <= '0;
      refused_q <= 1'b0;
    end else if (accept_i) begin
      cursor_q  <= cursor_d;
      refused_q <= refused_d;
    end
  end

endmodule

[hw/rtl/lsbp_queue.sv]
// short queue of classified chunks between front and back
module lsbp_queue import lsbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lsbp_op_t op_i,
  input  logic     pop_i,
  output lsbp_op_t head_o,
  output logic     valid_o,
  output logic     full_o
);

  lsbp_op_t             ent_q [QueueDepth];
  logic [QueuePtrW-1:0] wptr_q, rptr_q;
  logic [QueuePtrW:0]   count_q;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == (QueuePtrW + 1)'(QueueDepth));
  assign head_o  = ent_q[rptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= op_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/lsbp_back.sv]
// back end: byte read-modify-write on the buffer ram and result queue
module lsbp_back import lsbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lsbp_op_t  head_i,
  input  logic      head_valid_i,
  output logic      head_pop_o,
  output logic      clearing_o,
  output lsbp_res_t res_o,
  output logic      res_valid_o,
  input  logic      res_pop_i
);

  // clearing pass
  logic             clearing_q;
  logic [AddrW-1:0] clr_addr_q;

  // issue stage
  logic             sub_q;
  logic [AddrW-1:0] op_addr;
  logic [DataW-1:0] op_mask, op_bits;
  logic             op_wv, op_last;
  logic             issue, leave;

  // merge stage
  logic             b1_vld_q;
  logic             b1_status_q, b1_wv_q, b1_last_q;
  logic [AddrW-1:0] b1_addr_q;
  logic [DataW-1:0] b1_mask_q, b1_bits_q;
  logic [CursorW-1:0] b1_cursor_q;
  logic [DataW-1:0] rdata, old_byte, new_byte;

  // last byte written, covers the read that raced it
  logic             lw_vld_q;
  logic [AddrW-1:0] lw_addr_q;
  logic [DataW-1:0] lw_val_q;

  // ram ports
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [DataW-1:0] ram_wdata;

  // result queue, two entries
  lsbp_res_t        res_q [2];
  logic             res_wptr_q, res_rptr_q;
  logic [1:0]       res_cnt_q;
  logic             res_full;
  lsbp_res_t        res_new;

  // clear the buffer byte by byte after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AddrW'(BufferBytes - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  assign clearing_o = clearing_q;

  // select the byte lane of the head entry
  always_comb begin
    if (sub_q) begin
      op_addr = head_i.addr + 1'b1;
      op_mask = head_i.mask[2*DataW-1:DataW];
      op_bits = head_i.bits[2*DataW-1:DataW];
      op_wv   = 1'b1;
      op_last = 1'b1;
    end else begin
      op_addr = head_i.addr;
      op_mask = head_i.mask[DataW-1:0];
      op_bits = head_i.bits[DataW-1:0];
      op_wv   = head_i.wr_lo;
      op_last = !head_i.wr_hi;
    end
  end

  assign res_full   = (res_cnt_q == 2'd2);
  assign leave      = b1_vld_q && !res_full;
  assign issue      = head_valid_i && !clearing_q && (!b1_vld_q || !res_full);
  assign head_pop_o = issue && op_last;

  // lane counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else if (issue) begin
      sub_q <= !op_last;
    end
  end

  // merge stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
    end else if (issue) begin
      b1_vld_q <= 1'b1;
    end else if (leave) begin
      b1_vld_q <= 1'b0;
    end
  end

  // merge stage payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      b1_status_q <= head_i.status;
      b1_cursor_q <= head_i.cursor;
      b1_wv_q     <= op_wv;
      b1_last_q   <= op_last;
      b1_addr_q   <= op_addr;
      b1_mask_q   <= op_mask;
      b1_bits_q   <= op_bits;
    end
  end

  // buffer ram
  lsbp_ram #(
    .Width(DataW),
    .Depth(BufferBytes)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (issue && op_wv),
    .raddr_i(op_addr),
    .rdata_o(rdata)
  );

  // merge new bits over the old byte
  assign old_byte = (lw_vld_q && (lw_addr_q == b1_addr_q)) ? lw_val_q : rdata;
  assign new_byte = (old_byte & ~b1_mask_q) | b1_bits_q;

  // write port shared by the clearing pass and the merge stage
  always_comb begin
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = leave && b1_wv_q;
      ram_waddr = b1_addr_q;
      ram_wdata = new_byte;
    end
  end

  // track the most recent merged write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_vld_q <= 1'b0;
    end else if (leave && b1_wv_q) begin
      lw_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (leave && b1_wv_q) begin
      lw_addr_q <= b1_addr_q;
      lw_val_q  <= new_byte;
    end
  end

  // result record, address and value zero when nothing was written
  always_comb begin
    res_new.status      = b1_status_q;
    res_new.write_valid = b1_wv_q;
    res_new.addr        = b1_wv_q ? b1_addr_q : '0;
    res_new.value       = b1_wv_q ? new_byte : '0;
    res_new.cursor      = b1_cursor_q;
    res_new.last        = b1_last_q;
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (leave) begin
      res_q[res_wptr_q] <= res_new;
    end
  end

  // result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wptr_q <= 1'b0;
      res_rptr_q <= 1'b0;
      res_cnt_q  <= '0;
    end else begin
      if (leave) begin
        res_wptr_q <= !res_wptr_q;
      end
      if (res_pop_i) begin
        res_rptr_q <= !res_rptr_q;
      end
      if (leave && !res_pop_i) begin
        res_cnt_q <= res_cnt_q + 1'b1;
      end else if (!leave && res_pop_i) begin
        res_cnt_q <= res_cnt_q - 1'b1;
      end
    end
  end

  assign res_valid_o = (res_cnt_q != '0);
  assign res_o       = res_q[res_rptr_q];

endmodule

[hw/rtl/lsb_first_bit_packer_unit.sv]
// top level of the lsb-first bit packer
//
//   channel  | direction | transfer when         | fields
//   ---------+-----------+-----------------------+-----------------------------------------
//   chunks   | in        | push & !full          | data_bits, chunk_bits, first_of_call,
//            |           |                       | call_bits
//   results  | out       | pop & !empty          | status, write_valid, byte_address,
//            |           |                       | byte_value, bit_position, last
//   config   | in        | cfg_we_i              | cfg_wdata_i (capacity in bits)
//
// one chunk is taken per cycle if not full; a chunk touching two bytes gives two results,
// and the back end delivers one result per cycle, bound by one ram read-modify-write.
// a result passes the chunk queue, merge stage and result queue after its chunk transfer.
// after reset all BufferBytes (4096) bytes of the buffer ram are cleared, full stays high.
// a full result queue stalls the back end, which fills the chunk queue and raises full.
module lsb_first_bit_packer_unit import lsbp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CursorW-1:0]   cfg_wdata_i,
  // chunk input
  input  logic                 push,
  output logic                 full,
  input  logic [DataW-1:0]     data_bits_i,
  input  logic [ChunkW-1:0]    chunk_bits_i,
  input  logic                 first_of_call_i,
  input  logic [CursorW-1:0]   call_bits_i,
  // result output
  output logic                 empty,
  input  logic                 pop,
  output logic                 status_o,
  output logic                 write_valid_o,
  output logic [OutAddrW-1:0]  byte_address_o,
  output logic [DataW-1:0]     byte_value_o,
  output logic [CursorW-1:0]   bit_position_o,
  output logic                 last_o
);

  logic      accept;
  lsbp_op_t  front_op, head_op;
  logic      q_full, q_valid, q_pop;
  logic      clearing;
  lsbp_res_t res;
  logic      res_valid;

  // input transfer
  assign full   = q_full || clearing;
  assign accept = push && !full;

  // front end
  lsbp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .data_bits_i    (data_bits_i),
    .chunk_bits_i   (chunk_bits_i),
    .first_of_call_i(first_of_call_i),
    .call_bits_i    (call_bits_i),
    .op_o           (front_op)
  );

  // decoupling queue
  lsbp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .op_i   (front_op),
    .pop_i  (q_pop),
    .head_o (head_op),
    .valid_o(q_valid),
    .full_o (q_full)
  );

  // back end
  lsbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_op),
    .head_valid_i(q_valid),
    .head_pop_o  (q_pop),
    .clearing_o  (clearing),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_pop_i   (pop && res_valid)
  );

  // result ports
  assign empty          = !res_valid;
  assign status_o       = res.status;
  assign write_valid_o  = res.write_valid;
  assign byte_address_o = OutAddrW'(res.addr);
  assign byte_value_o   = res.value;
  assign bit_position_o = res.cursor;
  assign last_o         = res.last;

endmodule

[hw/rtl/lsbp_checker.sv]
// port-level checks of the bit packer and their binding to the top level
module lsbp_checker import lsbp_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic                status_o,
  input logic                write_valid_o,
  input logic [OutAddrW-1:0] byte_address_o,
  input logic [DataW-1:0]    byte_value_o,
  input logic [CursorW-1:0]  bit_position_o,
  input logic                last_o
);

  // a waiting result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(byte_value_o) && $stable(bit_position_o)))
    else $error("waiting result changed before its transfer");

  // a refused call never writes a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o) |-> !write_valid_o)
    else $error("byte written under a refused call");

  // a result without a write is the only and last one of its chunk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !write_valid_o) |-> (last_o && byte_address_o == '0 && byte_value_o == '0))
    else $error("result without write is not a clean final result");

  // the first of two writes is followed by the next byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && write_valid_o && !last_o) |=>
      (!empty && write_valid_o && last_o &&
       byte_address_o == $past(byte_address_o) + 1'b1))
    else $error("second byte of a chunk missing or misplaced");

endmodule

bind lsb_first_bit_packer_unit lsbp_checker u_checker (.*);
